@@ src/psm_pkg.sv @@
// Shared types, widths, operation codes and helpers for the segment merge block.
`timescale 1ns / 1ps
package psm_pkg;

  localparam int COORD_W   = 24;
  localparam int ID_W      = 24;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int MAG_W     = COORD_W;
  localparam int SUM_W     = 2 * MAG_W + 2;
  localparam int DOT_W     = SUM_W + 1;
  localparam int AW        = 2 * SUM_W;
  localparam int COS_W     = 16;
  localparam int COS_FRAC  = 14;
  localparam int CSQ_W     = 2 * COS_W;
  localparam int PW        = AW + CSQ_W;
  localparam int TOL_W     = 32;
  localparam int CFG_W     = 32;
  localparam int DIG_W     = 8;
  localparam int NDIG_MAX  = (SUM_W + DIG_W - 1) / DIG_W;
  localparam int BREG_W    = NDIG_MAX * DIG_W;
  localparam int DCNT_W    = $clog2(NDIG_MAX + 1);

  localparam logic [DCNT_W-1:0] MAG_DIG = DCNT_W'((MAG_W + DIG_W - 1) / DIG_W);
  localparam logic [DCNT_W-1:0] SUM_DIG = DCNT_W'((SUM_W + DIG_W - 1) / DIG_W);
  localparam logic [DCNT_W-1:0] COS_DIG = DCNT_W'((COS_W + DIG_W - 1) / DIG_W);
  localparam logic [DCNT_W-1:0] CSQ_DIG = DCNT_W'((CSQ_W + DIG_W - 1) / DIG_W);

  localparam logic [0:0] CFG_COS = 1'd0;
  localparam logic [0:0] CFG_TOL = 1'd1;
  localparam logic signed [COS_W-1:0] COS_RESET = 16'sd15826;
  localparam logic [TOL_W-1:0] TOL_RESET = 32'd655;

  typedef enum logic [3:0] {
    OP_GAP0, OP_GAP1, OP_GAP2,
    OP_LA0,  OP_LA1,  OP_LA2,
    OP_LB0,  OP_LB1,  OP_LB2,
    OP_DOT0, OP_DOT1, OP_DOT2,
    OP_DSQ,  OP_CSQ,  OP_LAB, OP_RHS
  } mul_op_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] start_z;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic signed [COORD_W-1:0] end_z;
    logic [ID_W-1:0]           polygon_id;
    logic                      last_in;
  } seg_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_start_x;
    logic signed [COORD_W-1:0] out_start_y;
    logic signed [COORD_W-1:0] out_start_z;
    logic signed [COORD_W-1:0] out_end_x;
    logic signed [COORD_W-1:0] out_end_y;
    logic signed [COORD_W-1:0] out_end_z;
    logic [ID_W-1:0]           out_polygon_id;
    logic                      last_out;
  } seg_out_t;

  typedef struct packed {
    logic    cap_in;
    logic    mul_start;
    logic    mul_step;
    logic    commit;
    mul_op_e op;
    logic    upd_end;
    logic    replace;
    logic    emit;
    logic    emit_last;
    logic    clr_pv;
  } dp_cmd_t;

  typedef struct packed {
    logic pend_valid;
    logic mul_last;
    logic merge;
    logic out_free;
    logic last_in;
  } dp_sts_t;

  // Axis that a per-axis product works on.
  function automatic logic [1:0] op_axis(mul_op_e op);
    logic [1:0] k;
    unique case (op)
      OP_GAP0, OP_LA0, OP_LB0, OP_DOT0: k = 2'd0;
      OP_GAP1, OP_LA1, OP_LB1, OP_DOT1: k = 2'd1;
      OP_GAP2, OP_LA2, OP_LB2, OP_DOT2: k = 2'd2;
      default:                          k = 2'd0;
    endcase
    return k;
  endfunction

  // Multiplier digits to run for each product.
  function automatic logic [DCNT_W-1:0] op_digits(mul_op_e op);
    logic [DCNT_W-1:0] n;
    unique case (op)
      OP_DSQ, OP_LAB: n = SUM_DIG;
      OP_CSQ:         n = COS_DIG;
      OP_RHS:         n = CSQ_DIG;
      default:        n = MAG_DIG;
    endcase
    return n;
  endfunction

endpackage

@@ src/psm_ctrl.sv @@
// Controller state machine: sequences the products, the merge decision and the emits.
`timescale 1ns / 1ps
module psm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  psm_pkg::dp_sts_t  sts_i,
  output psm_pkg::dp_cmd_t  cmd_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LOAD   = 3'd1;
  localparam logic [2:0] ST_RUN    = 3'd2;
  localparam logic [2:0] ST_WRITE  = 3'd3;
  localparam logic [2:0] ST_DECIDE = 3'd4;
  localparam logic [2:0] ST_EMIT_O = 3'd5;
  localparam logic [2:0] ST_EMIT_L = 3'd6;

  logic [2:0]       state_q, state_d;
  psm_pkg::mul_op_e op_q, op_d;

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.op   = op_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap_in = 1'b1;
          op_d         = psm_pkg::OP_GAP0;
          state_d      = sts_i.pend_valid ? ST_LOAD : ST_DECIDE;
        end
      end
      ST_LOAD: begin
        cmd_o.mul_start = 1'b1;
        state_d         = ST_RUN;
      end
      ST_RUN: begin
        cmd_o.mul_step = 1'b1;
        if (sts_i.mul_last) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd_o.commit = 1'b1;
        if (op_q == psm_pkg::OP_RHS) begin
          state_d = ST_DECIDE;
        end else begin
          op_d    = psm_pkg::mul_op_e'(op_q + 4'd1);
          state_d = ST_LOAD;
        end
      end
      ST_DECIDE: begin
        if (sts_i.pend_valid && sts_i.merge) begin
          cmd_o.upd_end = 1'b1;
          state_d       = sts_i.last_in ? ST_EMIT_L : ST_IDLE;
        end else if (sts_i.pend_valid) begin
          state_d = ST_EMIT_O;
        end else begin
          cmd_o.replace = 1'b1;
          state_d       = sts_i.last_in ? ST_EMIT_L : ST_IDLE;
        end
      end
      ST_EMIT_O: begin
        if (sts_i.out_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.replace = 1'b1;
          state_d       = sts_i.last_in ? ST_EMIT_L : ST_IDLE;
        end
      end
      ST_EMIT_L: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_last = 1'b1;
          cmd_o.clr_pv    = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= psm_pkg::OP_GAP0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

endmodule

@@ src/psm_datapath.sv @@
// Datapath: item and pending registers, digit-serial multiplier, sums and output register.
`timescale 1ns / 1ps
module psm_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  psm_pkg::seg_in_t              in_item_i,
  input  logic                          cfg_we_i,
  input  logic [0:0]                    cfg_idx_i,
  input  logic [psm_pkg::CFG_W-1:0]     cfg_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output psm_pkg::seg_out_t             out_item_o,
  input  psm_pkg::dp_cmd_t              cmd_i,
  output psm_pkg::dp_sts_t              sts_o
);

  localparam int CW = psm_pkg::COORD_W;
  localparam int DW = psm_pkg::DIFF_W;

  psm_pkg::seg_in_t                 in_q;
  logic signed [CW-1:0]             ps_q [3];
  logic signed [CW-1:0]             pe_q [3];
  logic [psm_pkg::ID_W-1:0]         pid_q;
  logic                             pv_q;
  logic signed [psm_pkg::COS_W-1:0] cos_q;
  logic [psm_pkg::TOL_W-1:0]        tol_q;

  logic [psm_pkg::SUM_W-1:0]        gap_q, la_q, lb_q;
  logic signed [psm_pkg::DOT_W-1:0] dot_q;
  logic [psm_pkg::AW-1:0]           dsq_q, lab_q;
  logic [psm_pkg::CSQ_W-1:0]        csq_q;
  logic [psm_pkg::PW-1:0]           rhs_q;

  logic [psm_pkg::AW-1:0]           mca_q;
  logic [psm_pkg::BREG_W-1:0]       mcb_q;
  logic [psm_pkg::PW-1:0]           prod_q;
  logic [psm_pkg::DCNT_W-1:0]       dig_q;

  logic                             out_valid_q;
  psm_pkg::seg_out_t                out_q;

  logic signed [CW-1:0]             ns [3];
  logic signed [CW-1:0]             ne [3];
  logic [1:0]                       k;
  logic signed [DW-1:0]             g_diff, a_diff, b_diff;
  logic [DW-1:0]                    g_abs, a_abs, b_abs;
  logic [psm_pkg::MAG_W-1:0]        g_mag, a_mag, b_mag;
  logic                             dot_neg;
  logic [psm_pkg::DOT_W-1:0]        dot_abs;
  logic [psm_pkg::SUM_W-1:0]        dot_mag;
  logic signed [psm_pkg::COS_W:0]   cos_ext, cos_abs;
  logic [psm_pkg::COS_W-1:0]        cos_mag;
  logic [psm_pkg::AW-1:0]           op_a;
  logic [psm_pkg::BREG_W-1:0]       op_b;
  logic [psm_pkg::DCNT_W-1:0]       dig_idx;
  logic [psm_pkg::DIG_W-1:0]        digit;
  logic [psm_pkg::AW+psm_pkg::DIG_W-1:0] pp;
  logic [psm_pkg::PW-1:0]           lhs;
  logic                             gap_ok, angle_ok;

  assign ns[0] = in_q.start_x;
  assign ns[1] = in_q.start_y;
  assign ns[2] = in_q.start_z;
  assign ne[0] = in_q.end_x;
  assign ne[1] = in_q.end_y;
  assign ne[2] = in_q.end_z;

  assign k      = psm_pkg::op_axis(cmd_i.op);
  assign g_diff = DW'(ns[k]) - DW'(pe_q[k]);
  assign a_diff = DW'(pe_q[k]) - DW'(ps_q[k]);
  assign b_diff = DW'(ne[k]) - DW'(ns[k]);
  assign g_abs  = g_diff[DW-1] ? DW'(-g_diff) : DW'(g_diff);
  assign a_abs  = a_diff[DW-1] ? DW'(-a_diff) : DW'(a_diff);
  assign b_abs  = b_diff[DW-1] ? DW'(-b_diff) : DW'(b_diff);
  assign g_mag  = g_abs[psm_pkg::MAG_W-1:0];
  assign a_mag  = a_abs[psm_pkg::MAG_W-1:0];
  assign b_mag  = b_abs[psm_pkg::MAG_W-1:0];
  assign dot_neg = a_diff[DW-1] ^ b_diff[DW-1];

  assign dot_abs = dot_q[psm_pkg::DOT_W-1] ? psm_pkg::DOT_W'(-dot_q) : psm_pkg::DOT_W'(dot_q);
  assign dot_mag = dot_abs[psm_pkg::SUM_W-1:0];
  assign cos_ext = (psm_pkg::COS_W + 1)'(cos_q);
  assign cos_abs = cos_ext[psm_pkg::COS_W] ? -cos_ext : cos_ext;
  assign cos_mag = cos_abs[psm_pkg::COS_W-1:0];

  always_comb begin
    unique case (cmd_i.op)
      psm_pkg::OP_GAP0, psm_pkg::OP_GAP1, psm_pkg::OP_GAP2: begin
        op_a = psm_pkg::AW'(g_mag);
        op_b = psm_pkg::BREG_W'(g_mag);
      end
      psm_pkg::OP_LA0, psm_pkg::OP_LA1, psm_pkg::OP_LA2: begin
        op_a = psm_pkg::AW'(a_mag);
        op_b = psm_pkg::BREG_W'(a_mag);
      end
      psm_pkg::OP_LB0, psm_pkg::OP_LB1, psm_pkg::OP_LB2: begin
        op_a = psm_pkg::AW'(b_mag);
        op_b = psm_pkg::BREG_W'(b_mag);
      end
      psm_pkg::OP_DOT0, psm_pkg::OP_DOT1, psm_pkg::OP_DOT2: begin
        op_a = psm_pkg::AW'(a_mag);
        op_b = psm_pkg::BREG_W'(b_mag);
      end
      psm_pkg::OP_DSQ: begin
        op_a = psm_pkg::AW'(dot_mag);
        op_b = psm_pkg::BREG_W'(dot_mag);
      end
      psm_pkg::OP_CSQ: begin
        op_a = psm_pkg::AW'(cos_mag);
        op_b = psm_pkg::BREG_W'(cos_mag);
      end
      psm_pkg::OP_LAB: begin
        op_a = psm_pkg::AW'(la_q);
        op_b = psm_pkg::BREG_W'(lb_q);
      end
      psm_pkg::OP_RHS: begin
        op_a = lab_q;
        op_b = psm_pkg::BREG_W'(csq_q);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // Most significant digit first: shift the partial sum up, add the next row.
  assign dig_idx = dig_q - psm_pkg::DCNT_W'(1);
  assign digit   = mcb_q[psm_pkg::DIG_W*dig_idx +: psm_pkg::DIG_W];
  assign pp      = (psm_pkg::AW + psm_pkg::DIG_W)'(mca_q) *
                   (psm_pkg::AW + psm_pkg::DIG_W)'(digit);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_start) begin
      mca_q  <= op_a;
      mcb_q  <= op_b;
      prod_q <= '0;
      dig_q  <= psm_pkg::op_digits(cmd_i.op);
    end else if (cmd_i.mul_step) begin
      prod_q <= (prod_q << psm_pkg::DIG_W) + psm_pkg::PW'(pp);
      dig_q  <= dig_idx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      in_q  <= in_item_i;
      gap_q <= '0;
      la_q  <= '0;
      lb_q  <= '0;
      dot_q <= '0;
    end else if (cmd_i.commit) begin
      unique case (cmd_i.op)
        psm_pkg::OP_GAP0, psm_pkg::OP_GAP1, psm_pkg::OP_GAP2:
          gap_q <= gap_q + psm_pkg::SUM_W'(prod_q);
        psm_pkg::OP_LA0, psm_pkg::OP_LA1, psm_pkg::OP_LA2:
          la_q <= la_q + psm_pkg::SUM_W'(prod_q);
        psm_pkg::OP_LB0, psm_pkg::OP_LB1, psm_pkg::OP_LB2:
          lb_q <= lb_q + psm_pkg::SUM_W'(prod_q);
        psm_pkg::OP_DOT0, psm_pkg::OP_DOT1, psm_pkg::OP_DOT2:
          dot_q <= dot_neg ? dot_q - psm_pkg::DOT_W'(prod_q)
                           : dot_q + psm_pkg::DOT_W'(prod_q);
        psm_pkg::OP_DSQ: dsq_q <= psm_pkg::AW'(prod_q);
        psm_pkg::OP_CSQ: csq_q <= psm_pkg::CSQ_W'(prod_q);
        psm_pkg::OP_LAB: lab_q <= psm_pkg::AW'(prod_q);
        psm_pkg::OP_RHS: rhs_q <= prod_q;
        default: ;
      endcase
    end
  end

  // Exact angle test without roots: compare D^2 * 2^28 against c^2 * La * Lb.
  assign lhs    = psm_pkg::PW'({dsq_q, {(2 * psm_pkg::COS_FRAC){1'b0}}});
  assign gap_ok = gap_q < psm_pkg::SUM_W'(tol_q);
  always_comb begin
    if (!dot_q[psm_pkg::DOT_W-1]) begin
      angle_ok = cos_q[psm_pkg::COS_W-1] ? 1'b1 : (lhs > rhs_q);
    end else begin
      angle_ok = cos_q[psm_pkg::COS_W-1] ? (lhs < rhs_q) : 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.replace) begin
      ps_q[0] <= ns[0];
      ps_q[1] <= ns[1];
      ps_q[2] <= ns[2];
      pe_q[0] <= ne[0];
      pe_q[1] <= ne[1];
      pe_q[2] <= ne[2];
      pid_q   <= in_q.polygon_id;
    end else if (cmd_i.upd_end) begin
      pe_q[0] <= ne[0];
      pe_q[1] <= ne[1];
      pe_q[2] <= ne[2];
    end
    if (cmd_i.emit) begin
      out_q.out_start_x    <= ps_q[0];
      out_q.out_start_y    <= ps_q[1];
      out_q.out_start_z    <= ps_q[2];
      out_q.out_end_x      <= pe_q[0];
      out_q.out_end_y      <= pe_q[1];
      out_q.out_end_z      <= pe_q[2];
      out_q.out_polygon_id <= pid_q;
      out_q.last_out       <= cmd_i.emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
      cos_q       <= psm_pkg::COS_RESET;
      tol_q       <= psm_pkg::TOL_RESET;
    end else begin
      if (cmd_i.clr_pv) begin
        pv_q <= 1'b0;
      end else if (cmd_i.replace) begin
        pv_q <= 1'b1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          psm_pkg::CFG_COS: cos_q <= cfg_data_i[psm_pkg::COS_W-1:0];
          psm_pkg::CFG_TOL: tol_q <= cfg_data_i[psm_pkg::TOL_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_item_o       = out_q;
  assign sts_o.pend_valid = pv_q;
  assign sts_o.mul_last   = (dig_q == psm_pkg::DCNT_W'(1));
  assign sts_o.merge      = gap_ok && angle_ok;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;
  assign sts_o.last_in    = in_q.last_in;

endmodule

@@ src/polyline_segment_merge_pass.sv @@
// Top level of the polyline segment merge pass: controller plus datapath.
`timescale 1ns / 1ps
// Usage
//   Input channel (in_valid_i / in_ready_o / in_item_i) takes one 3D segment per item.
//   The block holds one pending segment; a new item that joins it within the gap
//   tolerance and bends less than the angle limit extends it, otherwise the pending
//   segment goes out on the output channel (out_valid_o / out_ready_i / out_item_o)
//   and the new item becomes pending. An item with last_in set flushes the pending
//   segment with last_out set, so one item yields zero, one or two output items.
//   Config port: write cos_threshold (index 0) or join_tol_sq (index 1) while idle.
// Sequence
//   With no pending segment an item is decided in the cycle after it is taken. Otherwise
//   the next item can be taken only after sixteen products run through one
//   100x8 bit digit-serial multiplier (12 axis products of 3 digits, the 7-digit
//   dot square and length product, 2 and 4 digit cosine products), each with a load
//   and a write-back step, then one decide step. Each emit adds an emit step.
// Reset and stall
//   Reset drops the pending segment and the output item and restores the config
//   defaults. A stalled receiver holds the output register; the block waits in its
//   emit step, and only then takes the next input item.
module polyline_segment_merge_pass (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  psm_pkg::seg_in_t          in_item_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output psm_pkg::seg_out_t         out_item_o,
  input  logic                      cfg_we_i,
  input  logic [0:0]                cfg_idx_i,
  input  logic [psm_pkg::CFG_W-1:0] cfg_data_i
);

  psm_pkg::dp_cmd_t cmd;
  psm_pkg::dp_sts_t sts;

  // Sequence the products and emits.
  psm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Hold the item, pending segment, sums and output register.
  psm_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

@@ src/psm_checker.sv @@
// Port-level checker for the segment merge pass, bound to the top level.
`timescale 1ns / 1ps
module psm_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input psm_pkg::seg_out_t out_item_o
);

  // One item at a time: the block is busy right after taking an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while previous item in flight");

  // New output items are loaded only from a busy step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("output item loaded while idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled output item dropped or changed");

endmodule

bind polyline_segment_merge_pass psm_checker u_psm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

@@ test/tb_top.sv @@
// Testbench for the polyline segment merge pass: random segments, scoreboard, config sweeps.
`timescale 1ns / 1ps
module tb_top;
  import psm_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid;
  logic in_ready;
  seg_in_t in_item;
  logic out_valid;
  logic out_ready;
  seg_out_t out_item;
  logic cfg_we;
  logic [0:0] cfg_idx;
  logic [CFG_W-1:0] cfg_data;

  // Idle phase codes for the sender and receiver.
  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 200;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  polyline_segment_merge_pass dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Predictor state: pending segment and shadow config.
  logic signed [63:0] pend_start[3] = '{0, 0, 0};
  logic signed [63:0] pend_end[3] = '{0, 0, 0};
  logic [ID_W-1:0] pend_poly = '0;
  logic pend_live = 1'b0;
  logic signed [COS_W-1:0] cos_lim;
  logic [TOL_W-1:0] gap_tol;

  seg_in_t  seg_queue[$];
  seg_out_t merged_expect[$];
  idle_mode_e idle_mode = IDLE_NONE;
  bit hold_send = 1'b0;
  int mismatches = 0;
  int stall_cycles = 0;

  // Merge decision, exact with 256-bit math.
  function automatic bit joins(logic signed [63:0] ns[3], logic signed [63:0] ne[3]);
    logic signed [255:0] gap, la, lb, dot, g, da, db, lhs, rhs, c;
    gap = 0; la = 0; lb = 0; dot = 0;
    for (int k = 0; k < 3; k++) begin
      g  = ns[k] - pend_end[k];
      da = pend_end[k] - pend_start[k];
      db = ne[k] - ns[k];
      gap += g * g;
      la  += da * da;
      lb  += db * db;
      dot += da * db;
    end
    if (gap >= $signed({224'd0, gap_tol})) return 1'b0;
    c = cos_lim;
    lhs = dot * dot * (256'sd1 <<< (2 * COS_FRAC));
    rhs = c * c * la * lb;
    if (dot >= 0) return (c < 0) ? 1'b1 : (lhs > rhs);
    if (c >= 0) return 1'b0;
    return lhs < rhs;
  endfunction

  function automatic seg_out_t pending_seg(bit last);
    seg_out_t o;
    o.out_start_x = pend_start[0][COORD_W-1:0];
    o.out_start_y = pend_start[1][COORD_W-1:0];
    o.out_start_z = pend_start[2][COORD_W-1:0];
    o.out_end_x = pend_end[0][COORD_W-1:0];
    o.out_end_y = pend_end[1][COORD_W-1:0];
    o.out_end_z = pend_end[2][COORD_W-1:0];
    o.out_polygon_id = pend_poly;
    o.last_out = last;
    return o;
  endfunction

  // Advance the predictor by one accepted segment; queue what it emits.
  task automatic predict_merge(seg_in_t s);
    logic signed [63:0] ns[3], ne[3];
    ns[0] = s.start_x; ns[1] = s.start_y; ns[2] = s.start_z;
    ne[0] = s.end_x;   ne[1] = s.end_y;   ne[2] = s.end_z;
    if (pend_live && joins(ns, ne)) begin
      for (int k = 0; k < 3; k++) pend_end[k] = ne[k];
    end else begin
      if (pend_live) merged_expect.push_back(pending_seg(1'b0));
      for (int k = 0; k < 3; k++) begin
        pend_start[k] = ns[k];
        pend_end[k] = ne[k];
      end
      pend_poly = s.polygon_id;
      pend_live = 1'b1;
    end
    if (s.last_in) begin
      merged_expect.push_back(pending_seg(1'b1));
      pend_live = 1'b0;
    end
  endtask

  task automatic report(string what, seg_out_t got, seg_out_t want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  function automatic bit roll(int pct);
    return $urandom_range(99) < pct;
  endfunction

  // Driver: hold the item until accepted, then advance to the next one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_item <= '0;
    end else if (!in_valid || in_ready) begin
      if (seg_queue.size() > 0 && !hold_send &&
          !((idle_mode == IDLE_SEND || idle_mode == IDLE_BOTH) &&
            roll(idle_mode == IDLE_SEND ? 86 : 31))) begin
        in_item <= seg_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if (idle_mode == IDLE_RECV) out_ready <= !roll(86);
    else if (idle_mode == IDLE_BOTH) out_ready <= !roll(31);
    else out_ready <= 1'b1;
  end

  // Monitor: predict on input accept, check on output accept, run the watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) predict_merge(in_item);
      if (out_valid && out_ready) begin
        if (merged_expect.size() == 0) begin
          report("unexpected item", out_item, '0);
        end else begin
          seg_out_t want;
          want = merged_expect.pop_front();
          if (out_item.out_start_x !== want.out_start_x) report("start_x", out_item, want);
          if (out_item.out_start_y !== want.out_start_y) report("start_y", out_item, want);
          if (out_item.out_start_z !== want.out_start_z) report("start_z", out_item, want);
          if (out_item.out_end_x !== want.out_end_x) report("end_x", out_item, want);
          if (out_item.out_end_y !== want.out_end_y) report("end_y", out_item, want);
          if (out_item.out_end_z !== want.out_end_z) report("end_z", out_item, want);
          if (out_item.out_polygon_id !== want.out_polygon_id) report("polygon", out_item, want);
          if (out_item.last_out !== want.last_out) report("last_out", out_item, want);
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(9))
      0: return {1'b1, {(COORD_W-1){1'b0}}};
      1: return {1'b0, {(COORD_W-1){1'b1}}};
      2, 3, 4: return COORD_W'($signed($urandom_range(4000)) - 2000);
      default: return COORD_W'($urandom);
    endcase
  endfunction

  // Segment that continues from a given point, roughly along a direction.
  function automatic seg_in_t chain_seg(logic signed [COORD_W-1:0] sx, sy, sz,
                                        int dx, dy, dz, int jit, logic [ID_W-1:0] pid);
    seg_in_t s;
    s.start_x = sx + COORD_W'($signed($urandom_range(2*jit)) - jit);
    s.start_y = sy + COORD_W'($signed($urandom_range(2*jit)) - jit);
    s.start_z = sz;
    s.end_x = s.start_x + COORD_W'(dx + $signed($urandom_range(2*jit)) - jit);
    s.end_y = s.start_y + COORD_W'(dy + $signed($urandom_range(2*jit)) - jit);
    s.end_z = s.start_z + COORD_W'(dz);
    s.polygon_id = pid;
    s.last_in = 1'b0;
    return s;
  endfunction

  function automatic seg_in_t noise_seg();
    seg_in_t s;
    s.start_x = rand_coord(); s.start_y = rand_coord(); s.start_z = rand_coord();
    s.end_x = rand_coord();   s.end_y = rand_coord();   s.end_z = rand_coord();
    s.polygon_id = $urandom;
    s.last_in = roll(15);
    return s;
  endfunction

  // Queue one polyline: mostly well-formed chains, some broken ones.
  task automatic queue_polyline(int len);
    seg_in_t s;
    int dx, dy, dz, jit;
    logic [ID_W-1:0] pid;
    pid = $urandom;
    dx = $signed($urandom_range(2000)) - 1000;
    dy = $signed($urandom_range(2000)) - 1000;
    dz = $signed($urandom_range(200)) - 100;
    jit = roll(50) ? 0 : $urandom_range(1, 40);
    s = chain_seg(rand_coord(), rand_coord(), rand_coord(), dx, dy, dz, jit, pid);
    for (int i = 0; i < len; i++) begin
      if (roll(10)) s = noise_seg();
      else if (roll(10)) s = chain_seg(s.end_x, s.end_y, s.end_z, -dx, dy, dz, jit, pid);
      else if (roll(5)) s = chain_seg(s.end_x, s.end_y, s.end_z, 0, 0, 0, jit, pid);
      else s = chain_seg(s.end_x, s.end_y, s.end_z, dx, dy, dz, jit, $urandom);
      s.last_in = (i == len - 1) ? 1'b1 : 1'b0;
      seg_queue.push_back(s);
    end
  endtask

  task automatic wait_drained();
    while (seg_queue.size() > 0 || in_valid || merged_expect.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(logic [0:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_COS) cos_lim = val[COS_W-1:0];
    else gap_tol = val;
  endtask

  initial begin
    seg_in_t s;
    int cos_set[6];
    cfg_we = 1'b0;
    cfg_idx = CFG_COS;
    cfg_data = '0;
    cos_lim = COS_RESET;
    gap_tol = TOL_RESET;
    cos_set = '{16384, -16384, 0, 15826, 8192, -11585};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, straight chains, zero-length, lone last item, emit plus flush.
    s = '0;
    s.end_x = 1000;
    seg_queue.push_back(s);
    s.start_x = 1000; s.end_x = 2000; s.polygon_id = 24'hFFFFFF;
    seg_queue.push_back(s);
    s.start_x = 2000; s.end_x = 2000;
    seg_queue.push_back(s);
    s.start_x = 2000; s.end_x = 2000; s.end_y = 500; s.last_in = 1'b1;
    seg_queue.push_back(s);
    s = '0; s.last_in = 1'b1;
    seg_queue.push_back(s);
    s = '0;
    s.start_x = {1'b1, 23'd0}; s.start_y = {1'b1, 23'd0}; s.start_z = {1'b1, 23'd0};
    s.end_x = {1'b0, {23{1'b1}}}; s.end_y = {1'b0, {23{1'b1}}}; s.end_z = {1'b0, {23{1'b1}}};
    seg_queue.push_back(s);
    s.start_x = s.end_x; s.start_y = s.end_y; s.start_z = s.end_z;
    s.end_x = {1'b1, 23'd0}; s.polygon_id = 24'h5A5A5A;
    seg_queue.push_back(s);
    s.last_in = 1'b1; s.polygon_id = 24'hA5A5A5;
    s.start_x = 12; s.end_x = -12; s.start_y = 0; s.end_y = 0; s.start_z = 0; s.end_z = 0;
    seg_queue.push_back(s);
    for (int i = 0; i < 6; i++) seg_queue.push_back(noise_seg());
    seg_queue.push_back(chain_seg(0, 0, 0, 10, 0, 0, 0, 1));
    wait_drained();

    // Random phases across config settings and idle modes.
    for (int ph = 0; ph < 12; ph++) begin
      write_cfg(CFG_COS, CFG_W'(cos_set[ph % 6]));
      case (ph % 4)
        0: write_cfg(CFG_TOL, 32'hFFFFFFFF);
        1: write_cfg(CFG_TOL, 32'd0);
        2: write_cfg(CFG_TOL, 32'd655);
        default: write_cfg(CFG_TOL, $urandom_range(1, 5000));
      endcase
      idle_mode = idle_mode_e'(ph % 4);
      while (seg_queue.size() < 75) queue_polyline($urandom_range(1, 12));
      if (ph == 5) begin
        // Pause the sender until every expected item has come back.
        while (seg_queue.size() > 30) @(posedge clk);
        hold_send = 1'b1;
        while (merged_expect.size() > 0 || in_valid) @(posedge clk);
        hold_send = 1'b0;
      end
      wait_drained();
      s = noise_seg();
      s.last_in = 1'b1;
      seg_queue.push_back(s);
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/psm_pkg.sv
src/psm_ctrl.sv
src/psm_datapath.sv
src/polyline_segment_merge_pass.sv
src/psm_checker.sv
test/tb_top.sv
